FILE: rtl/jtsw_pkg.sv
`default_nettype none
package jtsw_pkg;

  // token codes
  localparam logic [3:0] OP_ARR_OPEN  = 4'd0;
  localparam logic [3:0] OP_ARR_CLOSE = 4'd1;
  localparam logic [3:0] OP_OBJ_OPEN  = 4'd2;
  localparam logic [3:0] OP_OBJ_CLOSE = 4'd3;
  localparam logic [3:0] OP_TRUE      = 4'd4;
  localparam logic [3:0] OP_FALSE     = 4'd5;
  localparam logic [3:0] OP_NULL      = 4'd6;
  localparam logic [3:0] OP_INT       = 4'd7;
  localparam logic [3:0] OP_STR_BEGIN = 4'd8;
  localparam logic [3:0] OP_STR_CHAR  = 4'd9;
  localparam logic [3:0] OP_STR_END   = 4'd10;

  // status codes
  localparam logic [2:0] ERR_OK            = 3'd0;
  localparam logic [2:0] ERR_BAD_ARR_OPEN  = 3'd1;
  localparam logic [2:0] ERR_BAD_ARR_CLOSE = 3'd2;
  localparam logic [2:0] ERR_BAD_OBJ_OPEN  = 3'd3;
  localparam logic [2:0] ERR_BAD_OBJ_CLOSE = 3'd4;
  localparam logic [2:0] ERR_BAD_VALUE     = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW      = 3'd6;
  localparam logic [2:0] ERR_STR_ORDER     = 3'd7;

  // scope kinds
  localparam logic [1:0] KIND_ROOT   = 2'd0;
  localparam logic [1:0] KIND_ARRAY  = 2'd1;
  localparam logic [1:0] KIND_OBJECT = 2'd2;

  // text bytes
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_U      = 8'h75;

  // keywords, first byte in the low lane
  localparam logic [47:0] KW_TRUE  = 48'h0000_6575_7274;
  localparam logic [47:0] KW_FALSE = 48'h0065_736c_6166;
  localparam logic [47:0] KW_NULL  = 48'h0000_6c6c_756e;

  // decimal digits of a 64-bit magnitude
  localparam int NUM_DIGITS = 20;
  localparam int BCD_W      = 4 * NUM_DIGITS;

  typedef struct packed {
    logic       key;
    logic       empty;
    logic [1:0] kind;
  } scope_t;

  localparam scope_t SCOPE_ROOT_INIT = '{key: 1'b1, empty: 1'b1, kind: KIND_ROOT};

  // classified token passed from front to back
  typedef struct packed {
    logic [3:0]  op;
    logic        neg;
    logic [63:0] mag;
    logic [47:0] esc;
    logic [2:0]  esc_len;
  } item_t;

  // scope marks after a member or element is complete
  function automatic scope_t scope_marks(scope_t s, logic k);
    scope_t r;
    r.kind  = s.kind;
    r.empty = 1'b0;
    r.key   = (s.kind == KIND_OBJECT) ? k : s.key;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/jtsw_ram.sv
`default_nettype none
module jtsw_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/jtsw_front.sv
`default_nettype none
module jtsw_front (
  input  wire logic        [3:0]  req_type,
  input  wire logic signed [63:0] operand_value,
  output jtsw_pkg::item_t         item
);
  logic [63:0] v;
  logic [7:0]  c;
  logic [7:0]  hex_lo;
  logic [7:0]  hex_hi;

  always_comb begin
    v      = operand_value;
    c      = v[7:0];
    hex_hi = jtsw_pkg::CH_ZERO + {4'd0, c[7:4]};
    hex_lo = (c[3:0] < 4'd10) ? (jtsw_pkg::CH_ZERO + {4'd0, c[3:0]})
                              : (8'h57 + {4'd0, c[3:0]});
    item.op  = req_type;
    item.neg = v[63];
    item.mag = v[63] ? (~v + 64'd1) : v;
    // escape sequence, first byte in the low lane
    item.esc     = {40'd0, c};
    item.esc_len = 3'd1;
    case (c)
      8'h22: begin item.esc = {32'd0, 8'h22, jtsw_pkg::CH_BSLASH}; item.esc_len = 3'd2; end
      8'h5c: begin item.esc = {32'd0, 8'h5c, jtsw_pkg::CH_BSLASH}; item.esc_len = 3'd2; end
      8'h08: begin item.esc = {32'd0, 8'h62, jtsw_pkg::CH_BSLASH}; item.esc_len = 3'd2; end
      8'h0c: begin item.esc = {32'd0, 8'h66, jtsw_pkg::CH_BSLASH}; item.esc_len = 3'd2; end
      8'h0a: begin item.esc = {32'd0, 8'h6e, jtsw_pkg::CH_BSLASH}; item.esc_len = 3'd2; end
      8'h0d: begin item.esc = {32'd0, 8'h72, jtsw_pkg::CH_BSLASH}; item.esc_len = 3'd2; end
      8'h09: begin item.esc = {32'd0, 8'h74, jtsw_pkg::CH_BSLASH}; item.esc_len = 3'd2; end
      default: begin
        if (c < 8'h20) begin
          item.esc = {hex_lo, hex_hi, jtsw_pkg::CH_ZERO, jtsw_pkg::CH_ZERO,
                      jtsw_pkg::CH_U, jtsw_pkg::CH_BSLASH};
          item.esc_len = 3'd6;
        end
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/jtsw_queue.sv
`default_nettype none
module jtsw_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire jtsw_pkg::item_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 q_valid,
  output jtsw_pkg::item_t      q_item
);
  jtsw_pkg::item_t slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_item  = slots[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= push_item;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/jtsw_back.sv
`default_nettype none
module jtsw_back #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire jtsw_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output logic [7:0]           out_byte,
  output logic                 byte_valid,
  output logic [2:0]           status,
  output logic                 last_of_run
);
  localparam int TW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EMIT  = 2'd1;
  localparam logic [1:0] S_CONV  = 2'd2;
  localparam logic [1:0] S_DIGIT = 2'd3;

  logic [1:0]            state;
  jtsw_pkg::scope_t      cur;
  logic [TW-1:0]         top;
  logic                  str_open;
  logic                  str_key;
  logic                  pop_pend;
  logic [47:0]           buffer;
  logic [2:0]            len;
  logic                  bv;
  logic [2:0]            code;
  logic                  int_mode;
  logic [jtsw_pkg::BCD_W-1:0] bcd;
  logic [jtsw_pkg::BCD_W-1:0] bcd_next;
  logic [63:0]           mag;
  logic [5:0]            cnt;
  logic [4:0]            rem;
  logic                  started;
  logic [3:0]            dig;
  logic                  out_free;
  logic                  emit;

  logic [3:0]            ram_rdata;

  // evaluation of the head token
  logic                  wk;
  logic                  wv;
  logic                  acomma;
  logic                  ev_fail;
  logic [2:0]            ev_code;
  logic [47:0]           ev_body;
  logic [2:0]            ev_blen;
  logic                  ev_comma;
  logic                  ev_push;
  logic                  ev_pop;
  logic [1:0]            ev_kind;
  logic                  ev_marks;
  logic                  ev_mk;
  logic                  ev_int;
  logic                  ev_open;
  logic                  ev_close_str;
  logic                  ev_key;
  logic [47:0]           ev_buf;
  logic [2:0]            ev_len;

  assign out_free = !res_valid || !res_stall;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign dig      = bcd[jtsw_pkg::BCD_W-1 -: 4];
  // a byte leaves the back end this cycle
  assign emit     = out_free &&
                    (((state == S_EMIT) && (len != 3'd0)) ||
                     ((state == S_DIGIT) && (started || dig != 4'd0 || rem == 5'd1)));

  jtsw_ram #(.WIDTH(4), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (q_pop && ev_push),
    .waddr (top),
    .wdata (cur),
    .raddr (top - TW'(1)),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < jtsw_pkg::NUM_DIGITS; i++) begin
      bcd_next[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3) : bcd[4*i +: 4];
    end
    bcd_next = {bcd_next[jtsw_pkg::BCD_W-2:0], mag[63]};
  end

  always_comb begin
    wk = (cur.kind == jtsw_pkg::KIND_OBJECT) && cur.key;
    wv = (cur.kind == jtsw_pkg::KIND_ARRAY) ||
         ((cur.kind == jtsw_pkg::KIND_OBJECT) && !cur.key) ||
         ((cur.kind == jtsw_pkg::KIND_ROOT) && cur.empty);
    acomma = (cur.kind == jtsw_pkg::KIND_ARRAY) && !cur.empty;
    ev_fail = 1'b0;
    ev_code = jtsw_pkg::ERR_OK;
    ev_body = 48'd0;
    ev_blen = 3'd0;
    ev_comma = 1'b0;
    ev_push = 1'b0;
    ev_pop = 1'b0;
    ev_kind = jtsw_pkg::KIND_ARRAY;
    ev_marks = 1'b0;
    ev_mk = 1'b1;
    ev_int = 1'b0;
    ev_open = 1'b0;
    ev_close_str = 1'b0;
    ev_key = 1'b0;
    if (q_item.op > jtsw_pkg::OP_STR_END) begin
      ev_fail = 1'b1;
      ev_code = jtsw_pkg::ERR_BAD_VALUE;
    end else if (str_open && q_item.op != jtsw_pkg::OP_STR_CHAR &&
                 q_item.op != jtsw_pkg::OP_STR_END) begin
      ev_fail = 1'b1;
      ev_code = jtsw_pkg::ERR_STR_ORDER;
    end else if (!str_open && (q_item.op == jtsw_pkg::OP_STR_CHAR ||
                               q_item.op == jtsw_pkg::OP_STR_END)) begin
      ev_fail = 1'b1;
      ev_code = jtsw_pkg::ERR_STR_ORDER;
    end else begin
      case (q_item.op)
        jtsw_pkg::OP_ARR_OPEN, jtsw_pkg::OP_OBJ_OPEN: begin
          if (!wv) begin
            ev_fail = 1'b1;
            ev_code = (q_item.op == jtsw_pkg::OP_ARR_OPEN) ? jtsw_pkg::ERR_BAD_ARR_OPEN
                                                           : jtsw_pkg::ERR_BAD_OBJ_OPEN;
          end else if (top >= TW'(STACK_DEPTH - 1)) begin
            ev_fail = 1'b1;
            ev_code = jtsw_pkg::ERR_OVERFLOW;
          end else begin
            ev_comma = acomma;
            ev_push  = 1'b1;
            ev_blen  = 3'd1;
            if (q_item.op == jtsw_pkg::OP_ARR_OPEN) begin
              ev_kind = jtsw_pkg::KIND_ARRAY;
              ev_body = {40'd0, jtsw_pkg::CH_LBRACK};
            end else begin
              ev_kind = jtsw_pkg::KIND_OBJECT;
              ev_body = {40'd0, jtsw_pkg::CH_LBRACE};
            end
          end
        end
        jtsw_pkg::OP_ARR_CLOSE: begin
          if (cur.kind != jtsw_pkg::KIND_ARRAY || top == '0) begin
            ev_fail = 1'b1;
            ev_code = jtsw_pkg::ERR_BAD_ARR_CLOSE;
          end else begin
            ev_body = {40'd0, jtsw_pkg::CH_RBRACK};
            ev_blen = 3'd1;
            ev_pop  = 1'b1;
          end
        end
        jtsw_pkg::OP_OBJ_CLOSE: begin
          if (!wk || top == '0) begin
            ev_fail = 1'b1;
            ev_code = jtsw_pkg::ERR_BAD_OBJ_CLOSE;
          end else begin
            ev_body = {40'd0, jtsw_pkg::CH_RBRACE};
            ev_blen = 3'd1;
            ev_pop  = 1'b1;
          end
        end
        jtsw_pkg::OP_TRUE, jtsw_pkg::OP_FALSE, jtsw_pkg::OP_NULL, jtsw_pkg::OP_INT: begin
          if (!wv) begin
            ev_fail = 1'b1;
            ev_code = jtsw_pkg::ERR_BAD_VALUE;
          end else begin
            ev_comma = acomma;
            ev_marks = 1'b1;
            if (q_item.op == jtsw_pkg::OP_TRUE) begin
              ev_body = jtsw_pkg::KW_TRUE;
              ev_blen = 3'd4;
            end else if (q_item.op == jtsw_pkg::OP_FALSE) begin
              ev_body = jtsw_pkg::KW_FALSE;
              ev_blen = 3'd5;
            end else if (q_item.op == jtsw_pkg::OP_NULL) begin
              ev_body = jtsw_pkg::KW_NULL;
              ev_blen = 3'd4;
            end else begin
              ev_int  = 1'b1;
              ev_body = q_item.neg ? {40'd0, jtsw_pkg::CH_MINUS} : 48'd0;
              ev_blen = q_item.neg ? 3'd1 : 3'd0;
            end
          end
        end
        jtsw_pkg::OP_STR_BEGIN: begin
          if (!wk && !wv) begin
            ev_fail = 1'b1;
            ev_code = jtsw_pkg::ERR_BAD_VALUE;
          end else begin
            ev_comma = acomma || (wk && !cur.empty);
            ev_body  = {40'd0, jtsw_pkg::CH_QUOTE};
            ev_blen  = 3'd1;
            ev_open  = 1'b1;
            ev_key   = wk;
          end
        end
        jtsw_pkg::OP_STR_CHAR: begin
          ev_body = q_item.esc;
          ev_blen = q_item.esc_len;
        end
        default: begin
          ev_body = str_key ? {32'd0, jtsw_pkg::CH_COLON, jtsw_pkg::CH_QUOTE}
                            : {40'd0, jtsw_pkg::CH_QUOTE};
          ev_blen = str_key ? 3'd2 : 3'd1;
          ev_marks = 1'b1;
          ev_mk = !str_key;
          ev_close_str = 1'b1;
        end
      endcase
    end
    if (ev_fail) begin
      ev_buf = 48'd0;
      ev_len = 3'd1;
    end else if (ev_comma) begin
      ev_buf = {ev_body[39:0], jtsw_pkg::CH_COMMA};
      ev_len = ev_blen + 3'd1;
    end else begin
      ev_buf = ev_body;
      ev_len = ev_blen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= jtsw_pkg::SCOPE_ROOT_INIT;
      top       <= '0;
      str_open  <= 1'b0;
      str_key   <= 1'b0;
      pop_pend  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (emit) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
      if (pop_pend) begin
        cur      <= jtsw_pkg::scope_marks(ram_rdata, 1'b1);
        pop_pend <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            buffer   <= ev_buf;
            len      <= ev_len;
            bv       <= !ev_fail;
            code     <= ev_code;
            int_mode <= ev_int;
            if (ev_push) begin
              top <= top + TW'(1);
              cur <= '{key: 1'b1, empty: 1'b1, kind: ev_kind};
            end
            if (ev_pop) begin
              top      <= top - TW'(1);
              pop_pend <= 1'b1;
            end
            if (ev_marks) cur <= jtsw_pkg::scope_marks(cur, ev_mk);
            if (ev_open) begin
              str_open <= 1'b1;
              str_key  <= ev_key;
            end
            if (ev_close_str) begin
              str_open <= 1'b0;
              str_key  <= 1'b0;
            end
            if (ev_int) begin
              mag     <= q_item.mag;
              bcd     <= '0;
              cnt     <= 6'd0;
              rem     <= 5'(jtsw_pkg::NUM_DIGITS);
              started <= 1'b0;
              state   <= S_CONV;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_CONV: begin
          bcd <= bcd_next;
          mag <= {mag[62:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_EMIT;
        end
        S_EMIT: begin
          if (len == 3'd0) begin
            state <= S_DIGIT;
          end else if (out_free) begin
            out_byte    <= buffer[7:0];
            byte_valid  <= bv;
            status      <= code;
            last_of_run <= (len == 3'd1) && !int_mode;
            buffer      <= {8'd0, buffer[47:8]};
            len         <= len - 3'd1;
            if (len == 3'd1) state <= int_mode ? S_DIGIT : S_IDLE;
          end
        end
        default: begin
          if (!started && dig == 4'd0 && rem != 5'd1) begin
            bcd <= {bcd[jtsw_pkg::BCD_W-5:0], 4'd0};
            rem <= rem - 5'd1;
          end else if (out_free) begin
            out_byte    <= jtsw_pkg::CH_ZERO | {4'd0, dig};
            byte_valid  <= 1'b1;
            status      <= jtsw_pkg::ERR_OK;
            last_of_run <= (rem == 5'd1);
            bcd         <= {bcd[jtsw_pkg::BCD_W-5:0], 4'd0};
            rem         <= rem - 5'd1;
            started     <= 1'b1;
            if (rem == 5'd1) state <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/json_token_stream_writer.sv
`default_nettype none
// Streaming JSON text writer. Each accepted transaction on the request side is
// one writer token (array/object open and close, true, false, null, a signed
// 64-bit integer, string begin, string character, string end); the block
// answers with one or more result transactions, each carrying one text byte,
// or a single bare status result (byte_valid low) when the token is illegal,
// and last_of_run marks the final result of each token. Separators, key colons
// and string escapes are inserted by the block. Nesting is bounded by
// STACK_DEPTH scopes, root included; an open at the limit reports overflow.
// The back end decodes a token and then emits its bytes one at a time while
// the result side is not stalled; an escaped string character yields up to
// six bytes. An integer first runs a binary-to-decimal conversion, then skips
// its leading zeros (up to 19) before its digits stream.
// The two-entry token queue lets the request side run ahead of the back end.
module json_token_stream_writer #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // request side
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic        [3:0]  req_type,
  input  wire logic signed [63:0] operand_value,
  // result side
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic             [7:0]  out_byte,
  output logic                    byte_valid,
  output logic             [2:0]  status,
  output logic                    last_of_run
);
  jtsw_pkg::item_t front_item;
  jtsw_pkg::item_t q_item;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;

  // front end: decode the token, precompute escapes and integer magnitude
  jtsw_front u_front (
    .req_type      (req_type),
    .operand_value (operand_value),
    .item          (front_item)
  );

  // token queue decouples acceptance from text generation
  jtsw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  assign req_stall = q_full;

  // back end: scope stack, legality checks and byte emission
  jtsw_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .status      (status),
    .last_of_run (last_of_run)
  );
endmodule
`default_nettype wire

FILE: rtl/jtsw_check.sv
`default_nettype none
module jtsw_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_stall,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic [2:0] status,
  input wire logic       last_of_run
);
  // stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  // a status result is always the only result of its token
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !byte_valid |-> last_of_run)
    else $error("status result not last of run");

  // byte results carry ok status
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && byte_valid |-> status == jtsw_pkg::ERR_OK)
    else $error("byte result with error status");

  // status results carry a zero byte and a nonzero code
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !byte_valid |-> out_byte == 8'd0 && status != jtsw_pkg::ERR_OK)
    else $error("malformed status result");
endmodule

bind json_token_stream_writer jtsw_check u_check (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .out_byte    (out_byte),
  .byte_valid  (byte_valid),
  .status      (status),
  .last_of_run (last_of_run)
);
`default_nettype wire
